@@ rtl/core/pali_pkg.sv @@
`timescale 1ns / 1ps
package pali_pkg;
   localparam int MaxPoints = 64;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = 7;
   localparam int SqW = 67;
   localparam int RootW = 34;
   localparam int CumW = 40;
   localparam int TqW = 17;
   localparam int TgtW = CumW + TqW;
   localparam int FracW = 17;

   localparam logic [0:0] KindLoad = 1'b0;
   localparam logic [0:0] KindQuery = 1'b1;
   localparam logic [0:0] CsrClosed = 1'b0;
   localparam logic [0:0] CsrPointCount = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TOO_FEW,
      ST_SUM_RD, ST_SUM_WAIT, ST_SUM_DIFF, ST_SUM_SQ, ST_SUM_ROOT, ST_SUM_ACC,
      ST_TARGET,
      ST_SRCH_RD, ST_SRCH_WAIT, ST_SRCH_CMP,
      ST_DIV, ST_LERP_RD, ST_LERP_WAIT, ST_LERP_MUL, ST_LERP_OUT
   } state_type;

   typedef struct packed {
      logic seg_clear;
      logic seg_next;
      logic addr_seg;
      logic addr_lerp;
      logic diff_load;
      logic sq_step;
      logic root_start;
      logic root_step;
      logic acc_add;
      logic target_load;
      logic cmp_load;
      logic found_set;
      logic div_start;
      logic div_step;
      logic mul_load;
      logic out_load;
      logic out_zero;
   } cmd_type;

   typedef struct packed {
      logic seg_last;
      logic sq_done;
      logic root_done;
      logic found_hit;
      logic div_done;
      logic too_few;
   } sts_type;
endpackage

@@ rtl/core/pali_dp.sv @@
`timescale 1ns / 1ps
module pali_dp (
   input  logic                clock,
   input  logic                reset,
   input  pali_pkg::cmd_type   cmd,
   output pali_pkg::sts_type   sts,
   input  logic                ld_en,
   input  logic [5:0]          ld_index,
   input  logic signed [31:0]  ld_x,
   input  logic signed [31:0]  ld_y,
   input  logic signed [31:0]  ld_z,
   input  logic                q_load,
   input  logic signed [23:0]  q_pos,
   input  logic                closed,
   input  logic [6:0]          count,
   output logic signed [31:0]  out_x,
   output logic signed [31:0]  out_y,
   output logic signed [31:0]  out_z,
   output logic                out_status
);
   localparam int IW = pali_pkg::IdxW;

   logic [31:0] xm [pali_pkg::MaxPoints];
   logic [31:0] ym [pali_pkg::MaxPoints];
   logic [31:0] zm [pali_pkg::MaxPoints];
   logic [31:0] cm_lo [pali_pkg::MaxPoints];
   logic [7:0]  cm_hi [pali_pkg::MaxPoints];

   logic [IW-1:0] seg_ff, seg_in, nxt, ra, rb;
   logic sel_ff, sel_in;
   logic [IW:0] n_eff;
   logic [IW:0] cnt;
   logic [31:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic [39:0] cum_rd_ff, prev_rd_ff;
   logic [32:0] d_ff [3];
   logic [1:0]  sq_ff;
   logic [pali_pkg::SqW-1:0] sum_ff;
   logic [65:0] prod;
   logic [pali_pkg::SqW-1:0] rem_ff;
   logic [pali_pkg::RootW-1:0] root_ff;
   logic [5:0] rbit_ff;
   logic [pali_pkg::SqW+1:0] trial;
   logic [pali_pkg::CumW-1:0] total_ff, cum_sum;
   logic [pali_pkg::TqW-1:0] tq_ff;
   logic [pali_pkg::TgtW-1:0] target_ff;
   logic [pali_pkg::TgtW-1:0] num_ff;
   logic [pali_pkg::CumW-1:0] seg_len_ff;
   logic [pali_pkg::FracW-1:0] frac_ff;
   logic [5:0] dbit_ff;
   logic [pali_pkg::TgtW-1:0] drem_ff;
   logic [pali_pkg::TgtW:0] dtry;
   logic found_ff;
   logic [IW-1:0] la_ff, lb_ff;
   logic signed [32:0] dl_ff [3];
   logic signed [50:0] mp_ff [3];
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic st_ff;

   // effective count and segment count
   always_comb begin
      n_eff = (count > 7'(pali_pkg::MaxPoints)) ? (IW+1)'(pali_pkg::MaxPoints)
                                                : count[IW:0];
      cnt = closed ? n_eff : n_eff - 1'b1;
      nxt = ((IW+1)'(seg_ff) + 1'b1 < n_eff) ? seg_ff + 1'b1 : '0;
   end
   assign sts.too_few = n_eff < 2;
   assign sts.seg_last = ((IW+1)'(seg_ff) + 1'b1) >= cnt;

   // point addresses
   always_comb begin
      ra = cmd.addr_lerp ? la_ff : seg_ff;
      rb = cmd.addr_lerp ? lb_ff : nxt;
   end

   // point store and cumulative length store
   always_ff @(posedge clock) begin
      if (ld_en) begin
         xm[ld_index] <= ld_x;
         ym[ld_index] <= ld_y;
         zm[ld_index] <= ld_z;
      end
      ax_ff <= xm[ra]; ay_ff <= ym[ra]; az_ff <= zm[ra];
      bx_ff <= xm[rb]; by_ff <= ym[rb]; bz_ff <= zm[rb];
      if (cmd.acc_add) begin
         cm_lo[seg_ff] <= cum_sum[31:0];
         cm_hi[seg_ff] <= cum_sum[39:32];
      end
      cum_rd_ff <= {cm_hi[seg_ff], cm_lo[seg_ff]};
      prev_rd_ff <= (seg_ff == '0) ? '0 : {cm_hi[seg_ff-1'b1], cm_lo[seg_ff-1'b1]};
   end

   // segment counter
   always_comb begin
      seg_in = seg_ff;
      if (cmd.seg_clear) seg_in = '0;
      else if (cmd.seg_next) seg_in = seg_ff + 1'b1;
   end

   // absolute differences
   function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] d;
      d = 33'(signed'(a)) - 33'(signed'(b));
      absd = d[32] ? 33'(-d) : 33'(d);
   endfunction

   assign prod = d_ff[sq_ff] * d_ff[sq_ff];
   assign cum_sum = total_ff + 40'(root_ff);
   assign trial = {2'b0, rem_ff} - ({2'b0, 33'b0, root_ff} << (rbit_ff + 1'b1))
                  - ((pali_pkg::SqW+2)'(1) << (2 * rbit_ff));
   assign dtry = {1'b0, drem_ff} - ({(pali_pkg::TgtW+1-pali_pkg::CumW)'(0), seg_len_ff}
                  << dbit_ff);
   assign sts.sq_done = sq_ff == 2'd2;
   assign sts.root_done = rbit_ff == '0;
   assign sts.div_done = dbit_ff == '0;
   assign sts.found_hit = ({cum_rd_ff, 16'b0}) > 56'(target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else begin
         seg_ff <= seg_in;
      end
      if (q_load) begin
         // fold t above one into (0,1], clamp negative to zero
         if (q_pos[23]) tq_ff <= '0;
         else if (q_pos > 24'sd65536) tq_ff <= 17'({1'b0, 16'(q_pos - 1'b1)}) + 1'b1;
         else tq_ff <= q_pos[16:0];
         total_ff <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.diff_load) begin
         d_ff[0] <= absd(bx_ff, ax_ff);
         d_ff[1] <= absd(by_ff, ay_ff);
         d_ff[2] <= absd(bz_ff, az_ff);
         sq_ff <= '0;
         sum_ff <= '0;
      end
      if (cmd.sq_step) begin
         sum_ff <= sum_ff + 67'(prod);
         if (!sts.sq_done) sq_ff <= sq_ff + 1'b1;
      end
      // one bit of the root per step, restoring
      if (cmd.root_start) begin
         rem_ff <= sum_ff;
         root_ff <= '0;
         rbit_ff <= 6'd33;
      end else if (cmd.root_step) begin
         if (!trial[pali_pkg::SqW+1]) begin
            rem_ff <= trial[pali_pkg::SqW-1:0];
            root_ff[rbit_ff] <= 1'b1;
         end
         if (!sts.root_done) rbit_ff <= rbit_ff - 1'b1;
      end
      if (cmd.acc_add) total_ff <= cum_sum;
      if (cmd.target_load) target_ff <= 57'(total_ff) * 57'(tq_ff);
      if (cmd.found_set) begin
         found_ff <= 1'b1;
         la_ff <= seg_ff;
         lb_ff <= nxt;
         seg_len_ff <= cum_rd_ff - prev_rd_ff;
         num_ff <= target_ff - {1'b0, prev_rd_ff, 16'b0};
      end
      if (cmd.cmp_load) begin
         la_ff <= closed ? '0 : IW'(n_eff - 1'b1);
         lb_ff <= closed ? '0 : IW'(n_eff - 1'b1);
      end
      // quotient fits 17 bits since numerator < 65536 * segment
      if (cmd.div_start) begin
         drem_ff <= num_ff;
         frac_ff <= '0;
         dbit_ff <= 6'd16;
      end else if (cmd.div_step) begin
         if (!dtry[pali_pkg::TgtW]) begin
            drem_ff <= dtry[pali_pkg::TgtW-1:0];
            frac_ff[dbit_ff[4:0]] <= 1'b1;
         end
         if (!sts.div_done) dbit_ff <= dbit_ff - 1'b1;
      end
      if (cmd.mul_load) begin
         dl_ff[0] <= 33'(signed'(bx_ff)) - 33'(signed'(ax_ff));
         dl_ff[1] <= 33'(signed'(by_ff)) - 33'(signed'(ay_ff));
         dl_ff[2] <= 33'(signed'(bz_ff)) - 33'(signed'(az_ff));
      end
      for (int k = 0; k < 3; k++)
         mp_ff[k] <= dl_ff[k] * $signed({1'b0, found_ff ? frac_ff : 17'd0});
      if (cmd.out_zero) begin
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0; st_ff <= 1'b1;
      end else if (cmd.out_load) begin
         ox_ff <= 32'(signed'(ax_ff) + 51'(mp_ff[0] / 51'sd65536));
         oy_ff <= 32'(signed'(ay_ff) + 51'(mp_ff[1] / 51'sd65536));
         oz_ff <= 32'(signed'(az_ff) + 51'(mp_ff[2] / 51'sd65536));
         st_ff <= 1'b0;
      end
   end

   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;
   assign out_status = st_ff;
endmodule

@@ rtl/core/pali_ctrl.sv @@
`timescale 1ns / 1ps
module pali_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               query,
   input  pali_pkg::sts_type  sts,
   output pali_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               done
);
   pali_pkg::state_type state_ff, state_in;
   logic div_first_ff;
   logic root_first_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pali_pkg::ST_IDLE:      if (query) state_in = sts.too_few ? pali_pkg::ST_TOO_FEW
                                                              : pali_pkg::ST_SUM_RD;
         pali_pkg::ST_TOO_FEW:   state_in = pali_pkg::ST_IDLE;
         pali_pkg::ST_SUM_RD:    state_in = pali_pkg::ST_SUM_WAIT;
         pali_pkg::ST_SUM_WAIT:  state_in = pali_pkg::ST_SUM_DIFF;
         pali_pkg::ST_SUM_DIFF:  state_in = pali_pkg::ST_SUM_SQ;
         pali_pkg::ST_SUM_SQ:    if (sts.sq_done) state_in = pali_pkg::ST_SUM_ROOT;
         pali_pkg::ST_SUM_ROOT:
            if (sts.root_done && !root_first_ff) state_in = pali_pkg::ST_SUM_ACC;
         pali_pkg::ST_SUM_ACC:   state_in = sts.seg_last ? pali_pkg::ST_TARGET
                                                         : pali_pkg::ST_SUM_RD;
         pali_pkg::ST_TARGET:    state_in = pali_pkg::ST_SRCH_RD;
         pali_pkg::ST_SRCH_RD:   state_in = pali_pkg::ST_SRCH_WAIT;
         pali_pkg::ST_SRCH_WAIT: state_in = pali_pkg::ST_SRCH_CMP;
         pali_pkg::ST_SRCH_CMP:
            if (sts.found_hit) state_in = pali_pkg::ST_DIV;
            else if (sts.seg_last) state_in = pali_pkg::ST_LERP_RD;
            else state_in = pali_pkg::ST_SRCH_RD;
         pali_pkg::ST_DIV:
            if (sts.div_done && !div_first_ff) state_in = pali_pkg::ST_LERP_RD;
         pali_pkg::ST_LERP_RD:   state_in = pali_pkg::ST_LERP_WAIT;
         pali_pkg::ST_LERP_WAIT: state_in = pali_pkg::ST_LERP_MUL;
         pali_pkg::ST_LERP_MUL:  state_in = pali_pkg::ST_LERP_OUT;
         pali_pkg::ST_LERP_OUT:  state_in = pali_pkg::ST_IDLE;
         default:                state_in = pali_pkg::ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= pali_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) div_first_ff <= 1'b0;
      else div_first_ff <= (state_ff == pali_pkg::ST_SRCH_CMP) && sts.found_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) root_first_ff <= 1'b0;
      else root_first_ff <= (state_ff == pali_pkg::ST_SUM_SQ) && sts.sq_done;
   end

   // outputs
   always_comb begin
      cmd = '0;
      busy = state_ff != pali_pkg::ST_IDLE;
      done = 1'b0;
      unique case (state_ff)
         pali_pkg::ST_IDLE:      cmd.seg_clear = 1'b1;
         pali_pkg::ST_TOO_FEW:   begin cmd.out_zero = 1'b1; done = 1'b1; end
         pali_pkg::ST_SUM_DIFF:  cmd.diff_load = 1'b1;
         pali_pkg::ST_SUM_SQ:    cmd.sq_step = !sts.sq_done || 1'b1;
         pali_pkg::ST_SUM_ROOT:  begin
            cmd.root_start = !root_first_ff ? 1'b0 : 1'b1;
            cmd.root_step = !root_first_ff;
         end
         pali_pkg::ST_SUM_ACC:   begin
            cmd.acc_add = 1'b1;
            cmd.seg_next = !sts.seg_last;
            cmd.seg_clear = sts.seg_last;
         end
         pali_pkg::ST_TARGET:    cmd.cmp_load = 1'b1;
         pali_pkg::ST_SRCH_CMP:  begin
            cmd.found_set = sts.found_hit;
            cmd.seg_next = !sts.found_hit && !sts.seg_last;
         end
         pali_pkg::ST_DIV:       begin
            cmd.div_start = div_first_ff;
            cmd.div_step = !div_first_ff;
         end
         pali_pkg::ST_LERP_RD:   cmd.addr_lerp = 1'b1;
         pali_pkg::ST_LERP_WAIT: begin cmd.addr_lerp = 1'b1; cmd.mul_load = 1'b1; end
         pali_pkg::ST_LERP_MUL:  cmd.addr_lerp = 1'b1;
         pali_pkg::ST_LERP_OUT:  begin
            cmd.addr_lerp = 1'b1; cmd.out_load = 1'b1; done = 1'b1;
         end
         default:                cmd = '0;
      endcase
      cmd.target_load = state_ff == pali_pkg::ST_TARGET;
      cmd.addr_seg = !cmd.addr_lerp;
   end
endmodule

@@ rtl/core/polyline_arc_length_interp_core.sv @@
`timescale 1ns / 1ps
// channel | ports                          | transfer when
// req     | start, req_* fields            | start && !busy
// rsp     | rsp_strobe, rsp_* fields       | rsp_strobe (one cycle)
// csr     | csr_valid/ready, index, data   | csr_valid && csr_ready
// A load writes the point store when taken. A query walks every segment
// (3 square steps, a root start and 34 root steps), then a target state, a
// search of each segment, a divider on a hit and the lerp states; the strobe
// follows in the next cycle. Fewer than two points: zero result, status set.
// Reset clears control state and csr registers; point store is unset until loaded.
// The receiver cannot stall the result.
module polyline_arc_length_interp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [5:0]         req_point_index,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [23:0] req_query_position,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [6:0]         csr_data
);
   pali_pkg::cmd_type cmd;
   pali_pkg::sts_type sts;
   logic closed_ff, ctl_busy, take, query, strobe_ff, ctl_done;
   logic [6:0] count_ff;

   assign take = start && !busy;
   assign query = take && (req_kind == pali_pkg::KindQuery);
   assign busy = ctl_busy;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 1'b0;
         count_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == pali_pkg::CsrClosed) closed_ff <= csr_data[0];
         else count_ff <= csr_data;
      end
   end

   // strobe registered from done, high while the result registers show the new result
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= ctl_done;
   end
   assign rsp_strobe = strobe_ff;

   pali_ctrl u_ctrl (
      .clock(clock), .reset(reset), .query(query), .sts(sts), .cmd(cmd),
      .busy(ctl_busy), .done(ctl_done)
   );

   pali_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .ld_en(take && (req_kind == pali_pkg::KindLoad)), .ld_index(req_point_index),
      .ld_x(req_point_x), .ld_y(req_point_y), .ld_z(req_point_z),
      .q_load(query), .q_pos(req_query_position),
      .closed(closed_ff), .count(count_ff),
      .out_x(rsp_out_x), .out_y(rsp_out_y), .out_z(rsp_out_z),
      .out_status(rsp_status)
   );
endmodule
